/* rtl/artl_pkg.sv */
// ----------------------------------------------------------------------------
// artl_pkg
// Shared types and constants for the address range table lookup unit.
// ----------------------------------------------------------------------------
package artl_pkg;

	// Default number of range entries
	localparam int unsigned DEFAULT_TABLE_DEPTH = 1024;

	// Fixed field widths
	localparam int unsigned ADDR_W        = 64;
	localparam int unsigned ENTRY_INDEX_W = 10;
	localparam int unsigned CFG_INDEX_W   = 1;
	localparam int unsigned CFG_DATA_W    = 64;

	// Input item kinds
	typedef enum logic {
		KIND_LOAD   = 1'b0,
		KIND_LOOKUP = 1'b1
	} kind_t;

	// Result status codes
	typedef enum logic [1:0] {
		STAT_HIT    = 2'd0,
		STAT_MISS   = 2'd1,
		STAT_STORED = 2'd2,
		STAT_FULL   = 2'd3
	} status_t;

	// Configuration register indexes
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_START_ADDRESS = 1'b0,
		REG_TEXT_OFFSET   = 1'b1
	} cfg_reg_t;

	// Sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_XADD,
		S_XSUB,
		S_CHECK,
		S_SEARCH,
		S_FINAL,
		S_DONE
	} state_t;

	// Input transaction payload
	typedef struct packed {
		logic              kind;
		logic [ADDR_W-1:0] addr;
		logic [ADDR_W-1:0] range_end;
		logic              kernel_addr;
	} in_item_t;

	// Output transaction payload
	typedef struct packed {
		status_t                  status;
		logic [ENTRY_INDEX_W-1:0] entry_index;
		logic [ADDR_W-1:0]        real_addr;
	} out_item_t;

	// One table entry as held in memory
	typedef struct packed {
		logic [ADDR_W-1:0] range_end;
		logic [ADDR_W-1:0] range_start;
	} range_entry_t;

endpackage

/* rtl/artl_ram.sv */
// ----------------------------------------------------------------------------
// artl_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module artl_ram #(
	parameter int unsigned WIDTH = 128,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/address_range_table_lookup_unit.sv */
// ----------------------------------------------------------------------------
// address_range_table_lookup_unit
// Load item: stored, then the result goes to the output register. Lookup item:
// translated, then done after the check on a last-hit match or an empty table,
// else a binary search of at most floor(log2(entry count)) + 1 steps.
// One item at a time; the next item is taken in the cycle after the result is
// handed to the output register. Each search step is one table memory read.
// Reset clears the entry count, the last-hit entry and both registers; table
// contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module address_range_table_lookup_unit
	import artl_pkg::*;
#(
	parameter int unsigned TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  in_item_t               in_data,
	output logic                   out_valid,
	input  logic                   out_ready,
	output out_item_t              out_data,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

	localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
	localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int unsigned RAM_W = $bits(range_entry_t);

	state_t state_q, state_d;

	logic [ADDR_W-1:0] start_q, text_q;
	logic [CNT_W-1:0]  count_q;
	logic              last_valid_q;
	logic [IDX_W-1:0]  last_idx_q;

	logic              kernel_q;
	logic [ADDR_W-1:0] ra_q;
	logic [CNT_W-1:0]  lo_q, hi_q, mid_q;

	status_t           res_status_q;
	logic [IDX_W-1:0]  res_idx_q;
	logic [ADDR_W-1:0] res_addr_q;

	logic              out_valid_q;
	out_item_t         out_data_q;

	logic              ram_we;
	logic [IDX_W-1:0]  ram_waddr, ram_raddr;
	range_entry_t      ram_wdata, ram_rdata;
	logic [RAM_W-1:0]  ram_rdata_raw;

	logic              accept, is_full;
	logic              cache_hit, final_hit, go_upper;
	logic [CNT_W-1:0]  lo_n, hi_n, mid_n, mid0;
	logic [CNT_W:0]    sum_n;
	logic              search_more;
	logic [ENTRY_INDEX_W-1:0] res_idx_out;

	assign accept  = in_valid && in_ready;
	assign is_full = (count_q >= CNT_W'(TABLE_DEPTH));

	// Table memory: {end, start} per entry
	artl_ram #(
		.WIDTH(RAM_W),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata_raw)
	);
	assign ram_rdata = range_entry_t'(ram_rdata_raw);

	// Compare the entry read back against the translated address
	assign cache_hit = last_valid_q && (ram_rdata.range_start <= ra_q) &&
		(ra_q < ram_rdata.range_end);
	assign final_hit = (lo_q < count_q) && (ram_rdata.range_start <= ra_q) &&
		(ra_q < ram_rdata.range_end);

	// Advance the binary search bounds from the entry at mid
	assign go_upper    = !(ram_rdata.range_end > ra_q);
	assign lo_n        = go_upper ? CNT_W'(mid_q + 1'b1) : lo_q;
	assign hi_n        = go_upper ? hi_q : mid_q;
	assign sum_n       = {1'b0, lo_n} + {1'b0, hi_n};
	assign mid_n       = sum_n[CNT_W:1];
	assign search_more = (lo_n < hi_n);
	assign mid0        = count_q >> 1;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = (in_data.kind == KIND_LOAD) ? S_DONE : S_XADD;
				end
			end
			S_XADD: state_d = S_XSUB;
			S_XSUB: state_d = S_CHECK;
			S_CHECK: begin
				if (cache_hit || count_q == '0) begin
					state_d = S_DONE;
				end else begin
					state_d = S_SEARCH;
				end
			end
			S_SEARCH: begin
				if (!search_more) begin
					state_d = S_FINAL;
				end
			end
			S_FINAL: state_d = S_DONE;
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Handshake and memory controls
	always_comb begin
		in_ready  = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = count_q[IDX_W-1:0];
		ram_wdata = '{range_end: in_data.range_end, range_start: in_data.addr};
		ram_raddr = '0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				ram_we   = in_valid && (in_data.kind == KIND_LOAD) && !is_full;
			end
			S_XSUB:   ram_raddr = last_idx_q;
			S_CHECK:  ram_raddr = mid0[IDX_W-1:0];
			S_SEARCH: ram_raddr = search_more ? mid_n[IDX_W-1:0] : lo_n[IDX_W-1:0];
			default:  ram_raddr = '0;
		endcase
	end

	// Sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
			text_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_START_ADDRESS: start_q <= cfg_wdata;
				REG_TEXT_OFFSET:   text_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Entry count and last-hit entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			last_valid_q <= 1'b0;
			last_idx_q   <= '0;
		end else if (accept && in_data.kind == KIND_LOAD) begin
			last_valid_q <= 1'b0;
			last_idx_q   <= '0;
			if (!is_full) begin
				count_q <= CNT_W'(count_q + 1'b1);
			end
		end else if (state_q == S_FINAL && final_hit) begin
			last_valid_q <= 1'b1;
			last_idx_q   <= lo_q[IDX_W-1:0];
		end
	end

	// Translate, search and build the result
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					kernel_q     <= in_data.kernel_addr;
					ra_q         <= in_data.addr;
					res_addr_q   <= '0;
					res_idx_q    <= is_full ? '0 : count_q[IDX_W-1:0];
					res_status_q <= is_full ? STAT_FULL : STAT_STORED;
				end
			end
			S_XADD: begin
				if (!kernel_q) begin
					ra_q <= ra_q + start_q;
				end
			end
			S_XSUB: begin
				if (!kernel_q) begin
					ra_q <= ra_q - text_q;
				end
			end
			S_CHECK: begin
				res_addr_q   <= ra_q;
				res_idx_q    <= cache_hit ? last_idx_q : '0;
				res_status_q <= cache_hit ? STAT_HIT : STAT_MISS;
				lo_q         <= '0;
				hi_q         <= count_q;
				mid_q        <= mid0;
			end
			S_SEARCH: begin
				lo_q  <= lo_n;
				hi_q  <= hi_n;
				mid_q <= mid_n;
			end
			S_FINAL: begin
				res_idx_q    <= final_hit ? lo_q[IDX_W-1:0] : '0;
				res_status_q <= final_hit ? STAT_HIT : STAT_MISS;
			end
			default: ;
		endcase
	end

	// Truncate or zero-extend the entry index to the result field width
	generate
		if (IDX_W >= ENTRY_INDEX_W) begin : g_idx_trunc
			assign res_idx_out = res_idx_q[ENTRY_INDEX_W-1:0];
		end else begin : g_idx_ext
			assign res_idx_out = {{(ENTRY_INDEX_W - IDX_W){1'b0}}, res_idx_q};
		end
	endgenerate

	// Output register: load on completion, drop on transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DONE && (!out_valid_q || out_ready)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && (!out_valid_q || out_ready)) begin
			out_data_q <= '{status: res_status_q, entry_index: res_idx_out,
				real_addr: res_addr_q};
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// Entry count never passes the table depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(TABLE_DEPTH))
		else $error("entry count beyond table depth");

	// Last-hit entry, when valid, always names a stored entry
	a_last_hit_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		last_valid_q |-> ({1'b0, last_idx_q} < {1'b0, count_q}))
		else $error("last-hit index outside the table");

	// A load into a table with room grows it by one
	a_load_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_data.kind == KIND_LOAD && !is_full) |=>
		(count_q == CNT_W'($past(count_q) + 1'b1)))
		else $error("load did not append an entry");

	// Search bounds stay ordered while searching
	a_search_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SEARCH) |-> (lo_q < hi_q && hi_q <= count_q))
		else $error("binary search bounds out of order");

endmodule
